### hw/rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sorted table search unit: request
// codes, field widths and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package sts_pkg;

   // Fixed field widths of the request/response channels
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 10;
   localparam int KEY_W    = 32;
   localparam int COUNT_W  = 11;
   localparam int RESULT_W = 11;

   // Parameter defaults
   localparam int DEF_TABLE_DEPTH = 1024;
   localparam int DEF_ENTRY_WIDTH = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_EXACT = 2'd1,
      CMD_FLOOR = 2'd2,
      CMD_CEIL  = 2'd3
   } cmd_type;

   // Controller -> datapath
   typedef struct packed {
      logic write;      // store the request's entry
      logic start;      // load key, mode and bounds for a new search
      logic probe;      // read the midpoint entry
      logic settle;     // act on the probed entry
      logic scan_rd;    // read the neighbor of the current match
      logic scan_take;  // move the match onto that neighbor
      logic load_out;   // move the result into the response register
   } dp_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic range_empty;  // low bound passed high bound
      logic match;        // entry read equals the key
      logic scan_edge;    // no neighbor left to scan
      logic exact_mode;   // search is exact mode
      logic out_free;     // response register can take a result
   } dp_status_type;

endpackage

### hw/rtl/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sts_ram #(
   parameter int WIDTH = sts_pkg::DEF_ENTRY_WIDTH,
   parameter int DEPTH = sts_pkg::DEF_TABLE_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import sts_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sts_ctrl.sv
// ----------------------------------------------------------------------------
// sts_ctrl
// Search controller: sequences the probe loop, the equal-run scan and the
// hand-off of each result to the response register.
// ----------------------------------------------------------------------------
module sts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  sts_pkg::dp_status_type status,
   output sts_pkg::dp_cmd_type    cmd
);
   import sts_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_PROBE   = 6'b000010,
      ST_COMPARE = 6'b000100,
      ST_SCAN_RD = 6'b001000,
      ST_SCAN_CK = 6'b010000,
      ST_FINISH  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      is_search;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign is_search = (cmd_type'(req_cmd) != CMD_WRITE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_search) begin
                  cmd.start = 1'b1;
                  state_in  = ST_PROBE;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            if (status.range_empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.probe = 1'b1;
               state_in  = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.settle = 1'b1;
            if (status.match) begin
               state_in = status.exact_mode ? ST_FINISH : ST_SCAN_RD;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_SCAN_RD: begin
            if (status.scan_edge) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CK;
            end
         end
         ST_SCAN_CK: begin
            if (status.match) begin
               cmd.scan_take = 1'b1;
               state_in      = ST_SCAN_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      accept && !is_search |=> state_ff == ST_IDLE)
      else $error("write request left the idle state");

   a_scan_not_exact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_RD || state_ff == ST_SCAN_CK) |-> !status.exact_mode)
      else $error("equal-run scan entered in exact mode");

endmodule

### hw/rtl/sts_dp.sv
// ----------------------------------------------------------------------------
// sts_dp
// Search datapath: entry table, count register, search bounds, compare
// logic and the response register.
// ----------------------------------------------------------------------------
module sts_dp #(
   parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
   parameter int ENTRY_WIDTH = sts_pkg::DEF_ENTRY_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sts_pkg::COUNT_W-1:0]         csr_write_data,
   input  logic [1:0]                          req_cmd,
   input  logic [sts_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic signed [sts_pkg::KEY_W-1:0]    req_key_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sts_pkg::RESULT_W-1:0] rsp_result_index,
   output logic                                rsp_exact_hit,
   input  sts_pkg::dp_cmd_type                 cmd,
   output sts_pkg::dp_status_type              status
);
   import sts_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int BW = ((AW + 1 > COUNT_W) ? AW + 1 : COUNT_W) + 1;
   localparam int CW = (ENTRY_WIDTH > KEY_W) ? ENTRY_WIDTH : KEY_W;

   logic [COUNT_W-1:0]         csr_count_ff, csr_count_in;
   logic signed [BW-1:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic signed [BW-1:0]       best_ff, best_in, cnt_ff, cnt_in;
   logic [AW-1:0]              mid_ff, mid_in;
   logic signed [KEY_W-1:0]    key_ff, key_in;
   cmd_type                    mode_ff, mode_in;
   logic                       hit_ff, hit_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0] rsp_index_ff, rsp_index_in;
   logic                       rsp_hit_ff, rsp_hit_in;

   logic signed [BW-1:0]       cnt_calc, span, mid_wide, mid_s, scan_s;
   logic [AW-1:0]              mid_calc, scan_addr;
   logic                       is_floor, is_ceil, write_ok;
   logic signed [CW-1:0]       entry_ext, key_ext;
   logic [ENTRY_WIDTH-1:0]     rd_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;

   // Clamp the programmed count to the table depth
   assign cnt_calc = (BW'(csr_count_ff) > BW'(TABLE_DEPTH)) ?
                     signed'(BW'(TABLE_DEPTH)) : signed'(BW'(csr_count_ff));

   assign span      = hi_ff - lo_ff;
   assign mid_wide  = lo_ff + (span >>> 1);
   assign mid_calc  = mid_wide[AW-1:0];
   assign mid_s     = signed'(BW'(mid_ff));
   assign is_floor  = (mode_ff == CMD_FLOOR);
   assign is_ceil   = (mode_ff == CMD_CEIL);
   assign scan_addr = is_floor ? (mid_ff - AW'(1)) : (mid_ff + AW'(1));
   assign scan_s    = signed'(BW'(scan_addr));
   assign write_ok  = (int'(req_entry_index) < TABLE_DEPTH);

   assign entry_ext = CW'(signed'(rd_data));
   assign key_ext   = CW'(key_ff);

   assign rd_en   = cmd.probe || cmd.scan_rd;
   assign rd_addr = cmd.probe ? mid_calc : scan_addr;

   sts_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write && write_ok),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (ENTRY_WIDTH'(req_key_value)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      status.range_empty = (lo_ff > hi_ff);
      status.match       = (entry_ext == key_ext);
      status.scan_edge   = is_floor ? (mid_ff == '0) : (mid_s >= cnt_ff - BW'(1));
      status.exact_mode  = (mode_ff == CMD_EXACT);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      csr_count_in = csr_write_enable ? csr_write_data : csr_count_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      best_in = best_ff;
      cnt_in  = cnt_ff;
      mid_in  = mid_ff;
      key_in  = key_ff;
      mode_in = mode_ff;
      hit_in  = hit_ff;
      if (cmd.start) begin
         key_in  = req_key_value;
         mode_in = cmd_type'(req_cmd);
         lo_in   = '0;
         hi_in   = cnt_calc - BW'(1);
         cnt_in  = cnt_calc;
         best_in = '1;
         hit_in  = 1'b0;
      end
      if (cmd.probe) begin
         mid_in = mid_calc;
      end
      if (cmd.settle) begin
         if (status.match) begin
            hit_in  = 1'b1;
            best_in = mid_s;
         end else if (key_ext < entry_ext) begin
            hi_in = mid_s - BW'(1);
            if (is_ceil) begin
               best_in = mid_s;
            end
         end else begin
            lo_in = mid_s + BW'(1);
            if (is_floor) begin
               best_in = mid_s;
            end
         end
      end
      if (cmd.scan_take) begin
         mid_in  = scan_addr;
         best_in = scan_s;
      end
   end

   // Response register: hold while stalled, drop once taken
   always_comb begin
      rsp_index_in = rsp_index_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = best_ff[RESULT_W-1:0];
         rsp_hit_in   = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         best_ff      <= '1;
         cnt_ff       <= '0;
         mode_ff      <= CMD_WRITE;
         hit_ff       <= 1'b0;
      end else begin
         csr_count_ff <= csr_count_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         best_ff      <= best_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      rsp_index_ff <= rsp_index_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_exact_hit    = rsp_hit_ff;

   a_exact_miss: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out && (mode_ff == CMD_EXACT) && !hit_ff |-> best_ff == '1)
      else $error("exact search miss without -1 result");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      !best_ff[BW-1] |-> best_ff < cnt_ff)
      else $error("best index beyond entry count");

   a_load_result: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff && (rsp_index_ff == $past(best_ff[RESULT_W-1:0])))
      else $error("response register missed a result");

endmodule

### hw/rtl/sorted_table_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_search_unit
// Table of signed entries with binary search returning an exact match, a
// floor or a ceiling index.
// ----------------------------------------------------------------------------
// A write request (cmd 0) stores key_value at entry_index and gives no
// response; indices at or beyond TABLE_DEPTH are dropped. A search
// request (cmd 1 exact, 2 floor, 3 ceil) binary-searches indices 0 to
// entry_count-1 (count clamped to TABLE_DEPTH) and gives exactly one
// response with the index found, or -1, and exact_hit. Each probe and each
// scan step is one read of the table RAM, whose registered read port puts
// an issue state and a compare state in each. A search makes at most
// floor(log2(entry_count))+1 probes, so up to 11 for a full 1024-entry
// table, and after a floor or ceil hit walks the equal neighbors until the
// table edge or a differing neighbor. The finished result waits while the
// response register is full and stalled, and shows on rsp_valid the cycle
// after it moves into the response register.
// One search is in flight at a time; req_stall is high from the cycle after
// a search is taken until its result moves into the response register,
// which holds it while rsp_stall is high, so the next request is taken
// while the last response waits.
// Program entry_count through csr_write_enable/csr_write_data only while
// no search is running.
module sorted_table_search_unit #(
   parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
   parameter int ENTRY_WIDTH = sts_pkg::DEF_ENTRY_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration: entry count in use
   input  logic                                csr_write_enable,
   input  logic [sts_pkg::COUNT_W-1:0]         csr_write_data,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sts_pkg::CMD_W-1:0]           req_cmd,
   input  logic [sts_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic signed [sts_pkg::KEY_W-1:0]    req_key_value,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sts_pkg::RESULT_W-1:0] rsp_result_index,
   output logic                                rsp_exact_hit
);
   import sts_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Controller: walks probe, compare, scan and finish steps
   sts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // Datapath: table RAM, bounds, compare and response register
   sts_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_cmd          (req_cmd),
      .req_entry_index  (req_entry_index),
      .req_key_value    (req_key_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_index (rsp_result_index),
      .rsp_exact_hit    (rsp_exact_hit),
      .cmd              (dp_cmd),
      .status           (dp_status)
   );

endmodule
